// ===== sv/hsv_pkg.sv =====
// ---------------------------------------------------------------------------
// hsv_pkg
// Shared constants, item type and helpers for the HSV to RGBA converter.
// ---------------------------------------------------------------------------
`default_nettype none

package hsv_pkg;

  // Fixed point: ONE = 1 << FRAC_BITS stands for 1.0
  localparam int FRAC_BITS = 8;
  localparam int UNIT_W    = FRAC_BITS + 1;
  localparam logic [UNIT_W-1:0] ONE = UNIT_W'(1 << FRAC_BITS);

  // Sector arithmetic: D = 60*ONE - s*r
  localparam int D_W = FRAC_BITS + 6;
  localparam logic [D_W-1:0] SIXTY_ONE = D_W'(60 << FRAC_BITS);

  // Product and scaling widths
  localparam int PQ_W     = UNIT_W + D_W;      // v * D
  localparam int MQ_W     = PQ_W + 5;          // v * D * 17
  localparam int QT_SHIFT = 2 * FRAC_BITS + 2; // 255/(60*ONE^2) = 17/(4*ONE^2)
  localparam int PP_W     = 2 * FRAC_BITS + 1; // v * (ONE - s)
  localparam int MP_W     = PP_W + 8;          // v * (ONE - s) * 255
  localparam int P_SHIFT  = 2 * FRAC_BITS;
  localparam int FULL_W   = UNIT_W + 8;        // v * 255

  // Remainder within a sector is 0..59
  localparam int REM_W = 6;
  localparam logic [REM_W-1:0] SECTOR_SPAN = REM_W'(60);

  // Hue sectors
  localparam logic [2:0] SEC_RED     = 3'd0;
  localparam logic [2:0] SEC_YELLOW  = 3'd1;
  localparam logic [2:0] SEC_GREEN   = 3'd2;
  localparam logic [2:0] SEC_CYAN    = 3'd3;
  localparam logic [2:0] SEC_BLUE    = 3'd4;
  localparam logic [2:0] SEC_MAGENTA = 3'd5;

  // Classified request passed from front to back
  typedef struct packed {
    logic [2:0]        sector;
    logic [REM_W-1:0]  rem;
    logic [UNIT_W-1:0] sat;
    logic [UNIT_W-1:0] val;
    logic [7:0]        alpha;
  } hsv_item_t;

  // Clamp a signed 10-bit fixed-point word into 0..ONE
  function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [9:0] x);
    logic [UNIT_W-1:0] res;
    if (x[9]) begin
      res = '0;
    end else if (UNIT_W'(x[8:0]) > ONE) begin
      res = ONE;
    end else begin
      res = UNIT_W'(x[8:0]);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/hsv_to_rgba_converter.sv =====
// ---------------------------------------------------------------------------
// hsv_to_rgba_converter
// HSV pixel in, RGBA pixel out, one request per clock unless the output stalls.
// ---------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | hue_deg, saturation, brightness, alpha_in
//  out     | out_valid / out_ready| red, green, blue, alpha_out
//
//  Sustains one request per cycle while the output is not stalled; a request
//  passes the front stage, a queue slot and the three back stages to out_valid.
//  Two multiplies set the clock: the back's 9x14 multiplier stage, and the
//  front's 14x11 reciprocal multiply for the hue wrap.
//  The four-entry queue absorbs output stalls; the front keeps accepting
//  until the queue and its own stage are full.
//  Synchronous reset clears all valid flags and queue pointers.
// ---------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgba_converter (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] hue_deg,
  input  wire logic signed [9:0]  saturation,
  input  wire logic signed [9:0]  brightness,
  input  wire logic [7:0]         alpha_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              red,
  output logic [7:0]              green,
  output logic [7:0]              blue,
  output logic [7:0]              alpha_out
);
  import hsv_pkg::*;

  hsv_item_t front_item;
  logic      front_valid;
  logic      front_ready;
  hsv_item_t back_item;
  logic      back_valid;
  logic      back_ready;

  hsv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .hue_deg    (hue_deg),
    .saturation (saturation),
    .brightness (brightness),
    .alpha_in   (alpha_in),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .item       (front_item),
    .item_valid (front_valid),
    .item_ready (front_ready)
  );

  hsv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (front_item),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_item   (back_item),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  hsv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (back_item),
    .item_valid (back_valid),
    .item_ready (back_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha_out  (alpha_out),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

endmodule

`default_nettype wire

// ===== sv/hsv_front.sv =====
// ---------------------------------------------------------------------------
// hsv_front
// Accept requests, wrap hue into 0..359, split it into sector and remainder,
// and clamp saturation and value.
// ---------------------------------------------------------------------------
`default_nettype none

module hsv_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic signed [15:0] hue_deg,
  input  wire logic signed [9:0]  saturation,
  input  wire logic signed [9:0]  brightness,
  input  wire logic [7:0]         alpha_in,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output hsv_pkg::hsv_item_t      item,
  output logic                    item_valid,
  input  wire logic               item_ready
);
  import hsv_pkg::*;

  // 92*360: lifts every 16-bit hue to a non-negative 17-bit value, same residue
  localparam logic [16:0] HUE_OFS   = 17'd33120;
  // floor(w*1456 >> 16) is w/45 or one less for w below 2^14
  localparam logic [10:0] RECIP_45  = 11'd1456;
  localparam int          RECIP_SH  = 16;
  localparam logic [13:0] DIV_45    = 14'd45;

  logic [16:0] hue_ofs;
  logic [24:0] quot_wide;

  logic              a_valid;
  logic [13:0]       a_w;
  logic [2:0]        a_low;
  logic [7:0]        a_qe;
  logic [UNIT_W-1:0] a_sat;
  logic [UNIT_W-1:0] a_val;
  logic [7:0]        a_alpha;

  logic [13:0]      rem_raw;
  logic [6:0]       rem45;
  logic [5:0]       rem45_fix;
  logic [8:0]       hue_mod;
  logic [2:0]       sector;
  logic [REM_W-1:0] rem;

  // Estimate hue/8 divided by 45
  always_comb begin
    hue_ofs   = {hue_deg[15], hue_deg} + HUE_OFS;
    quot_wide = 25'(hue_ofs[16:3]) * 25'(RECIP_45);
  end

  assign in_ready = !a_valid || item_ready;

  // Stage A: hold the quotient estimate and clamped fields
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_w     <= hue_ofs[16:3];
      a_low   <= hue_ofs[2:0];
      a_qe    <= quot_wide[RECIP_SH +: 8];
      a_sat   <= clamp_unit(saturation);
      a_val   <= clamp_unit(brightness);
      a_alpha <= alpha_in;
    end
  end

  // Correct the remainder, rebuild hue mod 360, split into sectors
  always_comb begin
    rem_raw   = a_w - (14'(a_qe) * DIV_45);
    rem45     = rem_raw[6:0];
    if (rem45 >= 7'(DIV_45)) begin
      rem45_fix = 6'(rem45 - 7'(DIV_45));
    end else begin
      rem45_fix = rem45[5:0];
    end
    hue_mod = {rem45_fix, a_low};

    if (hue_mod >= 9'd300) begin
      sector = SEC_MAGENTA;
      rem    = REM_W'(hue_mod - 9'd300);
    end else if (hue_mod >= 9'd240) begin
      sector = SEC_BLUE;
      rem    = REM_W'(hue_mod - 9'd240);
    end else if (hue_mod >= 9'd180) begin
      sector = SEC_CYAN;
      rem    = REM_W'(hue_mod - 9'd180);
    end else if (hue_mod >= 9'd120) begin
      sector = SEC_GREEN;
      rem    = REM_W'(hue_mod - 9'd120);
    end else if (hue_mod >= 9'd60) begin
      sector = SEC_YELLOW;
      rem    = REM_W'(hue_mod - 9'd60);
    end else begin
      sector = SEC_RED;
      rem    = REM_W'(hue_mod);
    end
  end

  always_comb begin
    item.sector = sector;
    item.rem    = rem;
    item.sat    = a_sat;
    item.val    = a_val;
    item.alpha  = a_alpha;
  end

  assign item_valid = a_valid;

endmodule

`default_nettype wire

// ===== sv/hsv_queue.sv =====
// ---------------------------------------------------------------------------
// hsv_queue
// Four-entry request queue between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module hsv_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire hsv_pkg::hsv_item_t push_item,
  input  wire logic          push_valid,
  output logic               push_ready,
  output hsv_pkg::hsv_item_t pop_item,
  output logic               pop_valid,
  input  wire logic          pop_ready
);
  import hsv_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  hsv_item_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             push;
  logic             pop;

  assign push_ready = (count != (PTR_W+1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr];

  // Store pushed requests
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/hsv_back.sv =====
// ---------------------------------------------------------------------------
// hsv_back
// Three-stage channel pipeline: sector terms, products, scaling and
// permutation into the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module hsv_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire hsv_pkg::hsv_item_t item,
  input  wire logic          item_valid,
  output logic               item_ready,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic [7:0]         alpha_out,
  output logic               out_valid,
  input  wire logic          out_ready
);
  import hsv_pkg::*;

  logic rdy1, rdy2, rdy3;

  // Stage 1 registers
  logic              b1_valid;
  logic [2:0]        b1_sector;
  logic [UNIT_W-1:0] b1_val;
  logic [D_W-1:0]    b1_dq;
  logic [D_W-1:0]    b1_dt;
  logic [UNIT_W-1:0] b1_dp;
  logic [7:0]        b1_full;
  logic [7:0]        b1_alpha;

  // Stage 2 registers
  logic              b2_valid;
  logic [2:0]        b2_sector;
  logic [PQ_W-1:0]   b2_pq;
  logic [PQ_W-1:0]   b2_pt;
  logic [PP_W-1:0]   b2_pp;
  logic [7:0]        b2_full;
  logic [7:0]        b2_alpha;

  logic [FULL_W-1:0] full_wide;
  logic [REM_W-1:0]  rem_inv;
  logic [MQ_W-1:0]   q_wide;
  logic [MQ_W-1:0]   t_wide;
  logic [MP_W-1:0]   p_wide;
  logic [7:0]        q_ch, t_ch, p_ch;
  logic [7:0]        r_next, g_next, b_next;

  // Stall chain from the output backward
  assign rdy3       = !out_valid || out_ready;
  assign rdy2       = !b2_valid || rdy3;
  assign rdy1       = !b1_valid || rdy2;
  assign item_ready = rdy1;

  always_comb begin
    full_wide = (FULL_W'(item.val) << 8) - FULL_W'(item.val);
    rem_inv   = SECTOR_SPAN - item.rem;
  end

  // Stage 1: form the sector terms
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (rdy1) begin
      b1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && item_valid) begin
      b1_sector <= item.sector;
      b1_val    <= item.val;
      b1_dq     <= SIXTY_ONE - (D_W'(item.sat) * D_W'(item.rem));
      b1_dt     <= SIXTY_ONE - (D_W'(item.sat) * D_W'(rem_inv));
      b1_dp     <= ONE - item.sat;
      b1_full   <= full_wide[FRAC_BITS +: 8];
      b1_alpha  <= item.alpha;
    end
  end

  // Stage 2: scale the terms by value
  always_ff @(posedge clk) begin
    if (rst) begin
      b2_valid <= 1'b0;
    end else if (rdy2) begin
      b2_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && b1_valid) begin
      b2_sector <= b1_sector;
      b2_pq     <= PQ_W'(b1_val) * PQ_W'(b1_dq);
      b2_pt     <= PQ_W'(b1_val) * PQ_W'(b1_dt);
      b2_pp     <= PP_W'(b1_val) * PP_W'(b1_dp);
      b2_full   <= b1_full;
      b2_alpha  <= b1_alpha;
    end
  end

  // Stage 3: constant scaling and channel permutation
  always_comb begin
    q_wide = (MQ_W'(b2_pq) << 4) + MQ_W'(b2_pq);
    t_wide = (MQ_W'(b2_pt) << 4) + MQ_W'(b2_pt);
    p_wide = (MP_W'(b2_pp) << 8) - MP_W'(b2_pp);
    q_ch   = q_wide[QT_SHIFT +: 8];
    t_ch   = t_wide[QT_SHIFT +: 8];
    p_ch   = p_wide[P_SHIFT +: 8];

    case (b2_sector)
      SEC_YELLOW: begin
        r_next = q_ch;    g_next = b2_full; b_next = p_ch;
      end
      SEC_GREEN: begin
        r_next = p_ch;    g_next = b2_full; b_next = t_ch;
      end
      SEC_CYAN: begin
        r_next = p_ch;    g_next = q_ch;    b_next = b2_full;
      end
      SEC_BLUE: begin
        r_next = t_ch;    g_next = p_ch;    b_next = b2_full;
      end
      SEC_MAGENTA: begin
        r_next = b2_full; g_next = p_ch;    b_next = q_ch;
      end
      default: begin
        r_next = b2_full; g_next = t_ch;    b_next = p_ch;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy3) begin
      out_valid <= b2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && b2_valid) begin
      red       <= r_next;
      green     <= g_next;
      blue      <= b_next;
      alpha_out <= b2_alpha;
    end
  end

endmodule

`default_nettype wire

// ===== sv/hsv_checker.sv =====
// ---------------------------------------------------------------------------
// hsv_checker
// Port-level checks for the HSV to RGBA converter.
// ---------------------------------------------------------------------------
`default_nettype none

module hsv_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  red,
  input wire logic [7:0]  green,
  input wire logic [7:0]  blue,
  input wire logic [7:0]  alpha_out
);

  // Leave reset empty and ready for a request
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("converter not empty and ready after reset");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(red) && $stable(green) && $stable(blue) && $stable(alpha_out)))
    else $error("stalled result changed or dropped");

  // One channel always bounds the others
  a_full_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((red >= green && red >= blue) ||
                   (green >= red && green >= blue) ||
                   (blue >= red && blue >= green)))
    else $error("no channel dominates");

  // An input stall with the output idle is followed by in_ready or out_valid
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !in_ready) |=> (in_ready || out_valid))
    else $error("input stalled with idle output");

endmodule

bind hsv_to_rgba_converter hsv_checker u_hsv_checker (.*);

`default_nettype wire

// ===== bench/hsv_to_rgba_checker.sv =====
// ---------------------------------------------------------------------------
// hsv_to_rgba_checker
// Watches both channels of the HSV to RGBA converter, predicts each pixel
// from the accepted request and compares it field by field with the result.
// ---------------------------------------------------------------------------
module hsv_to_rgba_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] hue_deg,
  input  logic signed [9:0]  saturation,
  input  logic signed [9:0]  brightness,
  input  logic [7:0]         alpha_in,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  input  logic [7:0]         alpha_out,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FX_ONE = 1 << hsv_pkg::FRAC_BITS;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  pixel_t rgba_queue[$];

  // Clamp a signed fixed-point word into 0..1.0
  function automatic longint unsigned clamp_fx(input logic signed [9:0] x);
    int xi;
    xi = x;
    if (xi < 0) return 0;
    if (xi > FX_ONE) return FX_ONE;
    return xi;
  endfunction

  // Convert one HSV request into the pixel the block must return
  function automatic pixel_t hsv_to_rgba(input logic signed [15:0] hue,
                                         input logic signed [9:0]  sat,
                                         input logic signed [9:0]  bri,
                                         input logic [7:0]         alpha);
    int                h;
    int unsigned       rem;
    logic [2:0]        sector;
    longint unsigned   s, v, one, span, full, p, q, t;
    pixel_t            px;
    h = int'(hue) % 360;
    if (h < 0) h += 360;
    sector = 3'(h / 60);
    rem    = h % 60;
    s      = clamp_fx(sat);
    v      = clamp_fx(bri);
    one    = FX_ONE;
    span   = 60 * one * one;
    full   = (v * 255) / one;
    p      = (v * (one - s) * 255) / (one * one);
    q      = (v * (60 * one - s * rem) * 255) / span;
    t      = (v * (60 * one - s * (60 - rem)) * 255) / span;
    px.alpha = alpha;
    case (sector)
      hsv_pkg::SEC_YELLOW:  begin px.red = q[7:0];    px.green = full[7:0]; px.blue = p[7:0];    end
      hsv_pkg::SEC_GREEN:   begin px.red = p[7:0];    px.green = full[7:0]; px.blue = t[7:0];    end
      hsv_pkg::SEC_CYAN:    begin px.red = p[7:0];    px.green = q[7:0];    px.blue = full[7:0]; end
      hsv_pkg::SEC_BLUE:    begin px.red = t[7:0];    px.green = p[7:0];    px.blue = full[7:0]; end
      hsv_pkg::SEC_MAGENTA: begin px.red = full[7:0]; px.green = p[7:0];    px.blue = q[7:0];    end
      default:              begin px.red = full[7:0]; px.green = t[7:0];    px.blue = p[7:0];    end
    endcase
    return px;
  endfunction

  // Report one field that differs from the prediction
  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Check results against the oldest prediction, then queue new requests
  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      rgba_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (rgba_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel: expected none, actual r=%0d g=%0d b=%0d a=%0d",
                   $time, red, green, blue, alpha_out);
        end else begin
          want = rgba_queue.pop_front();
          compare_field("red",   want.red,   red);
          compare_field("green", want.green, green);
          compare_field("blue",  want.blue,  blue);
          compare_field("alpha", want.alpha, alpha_out);
        end
      end
      if (in_valid && in_ready) begin
        rgba_queue.push_back(hsv_to_rgba(hue_deg, saturation, brightness, alpha_in));
      end
    end
    pending = rgba_queue.size();
  end

endmodule

// ===== bench/hsv_to_rgba_converter_tb.sv =====
// ---------------------------------------------------------------------------
// hsv_to_rgba_converter_tb
// Drives HSV requests in random bursts into the converter, stalls the pixel
// output on shifting patterns, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module hsv_to_rgba_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQS = 1500;
  localparam int IDLE_LIMIT  = 1000;
  localparam int DRAIN_WAIT  = 16;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_HOLD} rx_mode_e;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] hue_deg = '0;
  logic signed [9:0]  saturation = '0;
  logic signed [9:0]  brightness = '0;
  logic [7:0]         alpha_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [7:0]         alpha_out;
  int                 errors;
  int                 pending;

  int                 burst_left = 0;
  int                 idle_cycles = 0;
  rx_mode_e           rx_mode = RX_OPEN;
  int                 rx_left = 0;
  int                 rx_tick = 0;

  always #4 clk = ~clk;

  hsv_to_rgba_converter dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .hue_deg    (hue_deg),
    .saturation (saturation),
    .brightness (brightness),
    .alpha_in   (alpha_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha_out  (alpha_out)
  );

  hsv_to_rgba_checker pixel_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .hue_deg    (hue_deg),
    .saturation (saturation),
    .brightness (brightness),
    .alpha_in   (alpha_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha_out  (alpha_out),
    .errors     (errors),
    .pending    (pending)
  );

  // Send one request; open a new burst after a random gap when one ends
  task automatic send_hsv(input logic signed [15:0] hue, input logic signed [9:0] sat,
                          input logic signed [9:0] bri, input logic [7:0] alpha);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    hue_deg    <= hue;
    saturation <= sat;
    brightness <= bri;
    alpha_in   <= alpha;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // Pick a fixed-point level: mostly in range, sometimes any 10-bit word
  function automatic logic signed [9:0] rand_level();
    if ($urandom_range(0, 9) < 7) return 10'($urandom_range(0, 256));
    return 10'($urandom);
  endfunction

  // Stall the output on a pattern that changes mode now and then
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 12) : $urandom_range(8, 60);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:     out_ready <= 1'b1;
      RX_RANDOM:   out_ready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: out_ready <= (rx_tick % 3 == 0);
      default:     out_ready <= 1'b0;
    endcase
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: sector boundaries, hue wrap, clamping, alpha extremes
    send_hsv(16'sd0,     10'sd256,  10'sd256,  8'd255);
    send_hsv(16'sd59,    10'sd256,  10'sd256,  8'd0);
    send_hsv(16'sd60,    10'sd256,  10'sd256,  8'd128);
    send_hsv(16'sd120,   10'sd256,  10'sd256,  8'd1);
    send_hsv(16'sd180,   10'sd256,  10'sd256,  8'd254);
    send_hsv(16'sd240,   10'sd256,  10'sd256,  8'd85);
    send_hsv(16'sd300,   10'sd256,  10'sd256,  8'd170);
    send_hsv(16'sd359,   10'sd200,  10'sd180,  8'd255);
    send_hsv(16'sd360,   10'sd128,  10'sd256,  8'd0);
    send_hsv(-16'sd1,    10'sd256,  10'sd256,  8'd7);
    send_hsv(-16'sd360,  10'sd100,  10'sd200,  8'd9);
    send_hsv(-16'sd32768, 10'sd256, 10'sd256,  8'd255);
    send_hsv(16'sd32767, 10'sd256,  10'sd256,  8'd0);
    send_hsv(16'sd90,    -10'sd512, 10'sd256,  8'd33);
    send_hsv(16'sd90,    10'sd511,  10'sd256,  8'd44);
    send_hsv(16'sd150,   10'sd257,  10'sd200,  8'd55);
    send_hsv(16'sd210,   -10'sd1,   10'sd200,  8'd66);
    send_hsv(16'sd270,   10'sd0,    10'sd200,  8'd77);
    send_hsv(16'sd30,    10'sd256,  -10'sd512, 8'd88);
    send_hsv(16'sd30,    10'sd256,  10'sd511,  8'd99);
    send_hsv(16'sd330,   10'sd180,  10'sd257,  8'd111);
    send_hsv(16'sd330,   10'sd180,  -10'sd1,   8'd122);
    send_hsv(16'sd45,    10'sd180,  10'sd0,    8'd133);
    send_hsv(16'sd1,     10'sd1,    10'sd1,    8'd144);

    // Random: hue over the whole word or one turn, levels mostly in range
    for (int i = 0; i < RANDOM_REQS; i++) begin
      send_hsv(($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 359)),
               rand_level(), rand_level(), 8'($urandom));
    end
    in_valid <= 1'b0;
    @(posedge clk);

    // Drain the pipeline, then give the verdict
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== hsv_to_rgba_converter.f =====
sv/hsv_pkg.sv
sv/hsv_front.sv
sv/hsv_queue.sv
sv/hsv_back.sv
sv/hsv_to_rgba_converter.sv
sv/hsv_checker.sv
bench/hsv_to_rgba_checker.sv
bench/hsv_to_rgba_converter_tb.sv
